>>> design/gaussian_blur_2d_stream_macros.svh
// Assertion macros shared by the Gaussian blur checker.
`ifndef GAUSSIAN_BLUR_2D_STREAM_MACROS_SVH
`define GAUSSIAN_BLUR_2D_STREAM_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define GB2D_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define GB2D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/gb2d_pkg.sv
// Shared types, constants and the kernel distance-class function of the blur block.
`timescale 1ns / 1ps

package gb2d_pkg;

  localparam int KERNEL_SIZE    = 5;
  localparam int HALF_K         = KERNEL_SIZE / 2;
  localparam int COEF_FRAC_BITS = 14;
  localparam int DEF_MAX_WIDTH  = 1024;

  localparam int PIX_W      = 8;
  localparam int COEF_W     = 16;
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 12;
  localparam int OUT_X_W    = 10;
  localparam int OUT_Y_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int NUM_CLASSES   = 6;
  // Largest number of window taps sharing one distance class.
  localparam int MAX_CLASS_CNT = 8;
  localparam int CLS_SUM_W     = PIX_W + $clog2(MAX_CLASS_CNT);
  localparam int PROD_W        = CLS_SUM_W + COEF_W;
  localparam int NUM_PAIRS     = NUM_CLASSES / 2;
  localparam int PAIR_W        = PROD_W + 1;
  localparam int TOTAL_W       = PAIR_W + $clog2(NUM_PAIRS + 1);
  localparam int PIX_MAX       = 255;

  localparam int OUT_FIFO_DEPTH = 8;

  localparam logic [IMG_W_W-1:0] RST_IMAGE_WIDTH  = IMG_W_W'(640);
  localparam logic [IMG_H_W-1:0] RST_IMAGE_HEIGHT = IMG_H_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_COEF_D00,
    REG_COEF_D01,
    REG_COEF_D11,
    REG_COEF_D02,
    REG_COEF_D12,
    REG_COEF_D22
  } cfg_reg_e;

  typedef enum logic [2:0] {
    CLS_D00,
    CLS_D01,
    CLS_D11,
    CLS_D02,
    CLS_D12,
    CLS_D22
  } cls_e;

  typedef logic [PIX_W-1:0]       pix_t;
  typedef pix_t [KERNEL_SIZE-2:0] lb_word_t;
  typedef pix_t [KERNEL_SIZE-1:0] col_t;
  typedef logic [COEF_W-1:0]      coef_t;
  typedef logic [CLS_SUM_W-1:0]   cls_sum_t;

  typedef struct packed {
    pix_t pixel_in;
    logic start_of_frame;
  } in_item_t;

  typedef struct packed {
    pix_t               pixel_out;
    logic [OUT_X_W-1:0] out_x;
    logic [OUT_Y_W-1:0] out_y;
  } out_item_t;

  // Per-item control that travels alongside the arithmetic pipeline.
  typedef struct packed {
    logic               emit;
    logic               inner;
    logic [OUT_X_W-1:0] out_x;
    logic [OUT_Y_W-1:0] out_y;
  } gb2d_tag_t;

  // Distance class of window tap (r, c) relative to the window center.
  function automatic cls_e class_of(int r, int c);
    int   dy;
    int   dx;
    int   lo;
    int   hi;
    cls_e cls;
    dy = (r >= HALF_K) ? r - HALF_K : HALF_K - r;
    dx = (c >= HALF_K) ? c - HALF_K : HALF_K - c;
    lo = (dx < dy) ? dx : dy;
    hi = (dx < dy) ? dy : dx;
    if (hi == 0) begin
      cls = CLS_D00;
    end else if (hi == 1) begin
      cls = (lo == 0) ? CLS_D01 : CLS_D11;
    end else if (lo == 0) begin
      cls = CLS_D02;
    end else if (lo == 1) begin
      cls = CLS_D12;
    end else begin
      cls = CLS_D22;
    end
    return cls;
  endfunction

endpackage

>>> design/gb2d_line_buf.sv
// Line buffer memory: one word per column, read-modify-write with forwarding.
`timescale 1ns / 1ps

module gb2d_line_buf
  import gb2d_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  lb_word_t      wr_data_i,
  output lb_word_t      rd_data_o
);

  lb_word_t row_mem [MAX_WIDTH];
  lb_word_t rd_q;
  lb_word_t fwd_data_q;
  logic     fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      row_mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= row_mem[rd_addr_i];
    end
  end

  // A read issued in the same cycle as a write to the same column sees old data;
  // capture the write word and substitute it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (rd_addr_i == wr_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_data_q <= wr_data_i;
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

>>> design/gb2d_window.sv
// Pixel window shift register and per-distance-class pixel sums.
`timescale 1ns / 1ps

module gb2d_window
  import gb2d_pkg::*;
(
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             col_valid_i,
  input  col_t                             column_i,
  input  gb2d_tag_t                        tag_i,
  output logic                             sum_valid_o,
  output cls_sum_t [NUM_CLASSES-1:0]       sums_o,
  output gb2d_tag_t                        tag_o
);

  pix_t [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0] win_q;
  pix_t [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0] win_d;
  logic                                    s2_valid_q;
  gb2d_tag_t                               s2_tag_q;
  logic                                    s3_valid_q;
  cls_sum_t [NUM_CLASSES-1:0]              s3_sums_q;
  cls_sum_t [NUM_CLASSES-1:0]              sums_d;
  gb2d_tag_t                               s3_tag_q;

  // Shift every row one tap left and drop the new column in on the right.
  always_comb begin
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
        win_d[r][c] = win_q[r][c+1];
      end
      win_d[r][KERNEL_SIZE-1] = column_i[r];
    end
  end

  // Taps of equal distance share a weight, so add them before multiplying.
  always_comb begin
    for (int k = 0; k < NUM_CLASSES; k++) begin
      sums_d[k] = '0;
      for (int r = 0; r < KERNEL_SIZE; r++) begin
        for (int c = 0; c < KERNEL_SIZE; c++) begin
          if (class_of(r, c) == cls_e'(k)) begin
            sums_d[k] = sums_d[k] + CLS_SUM_W'(win_q[r][c]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= '0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (col_valid_i) begin
        win_q <= win_d;
      end
      s2_valid_q <= col_valid_i;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_tag_q  <= tag_i;
    s3_tag_q  <= s2_tag_q;
    s3_sums_q <= sums_d;
  end

  assign sum_valid_o = s3_valid_q;
  assign sums_o      = s3_sums_q;
  assign tag_o       = s3_tag_q;

endmodule

>>> design/gb2d_mac.sv
// Weighting, accumulation, scaling and saturation of the class sums.
`timescale 1ns / 1ps

module gb2d_mac
  import gb2d_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       sum_valid_i,
  input  cls_sum_t [NUM_CLASSES-1:0] sums_i,
  input  gb2d_tag_t                  tag_i,
  input  coef_t [NUM_CLASSES-1:0]    coefs_i,
  output logic                       done_o,
  output logic                       push_o,
  output out_item_t                  res_o
);

  logic                           p_valid_q;
  logic [NUM_CLASSES-1:0][PROD_W-1:0] prod_q;
  logic [NUM_CLASSES-1:0][PROD_W-1:0] prod_d;
  gb2d_tag_t                      p_tag_q;
  logic                           a_valid_q;
  logic [NUM_PAIRS-1:0][PAIR_W-1:0] pair_q;
  logic [NUM_PAIRS-1:0][PAIR_W-1:0] pair_d;
  gb2d_tag_t                      a_tag_q;
  logic [TOTAL_W-1:0]             total;
  logic [TOTAL_W-1:0]             scaled;
  pix_t                           sat_pix;

  always_comb begin
    for (int k = 0; k < NUM_CLASSES; k++) begin
      prod_d[k] = PROD_W'(sums_i[k]) * PROD_W'(coefs_i[k]);
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_PAIRS; i++) begin
      pair_d[i] = PAIR_W'(prod_q[2*i]) + PAIR_W'(prod_q[2*i+1]);
    end
  end

  // Floor by the fraction shift, then clamp to the pixel range.
  always_comb begin
    total = '0;
    for (int i = 0; i < NUM_PAIRS; i++) begin
      total = total + TOTAL_W'(pair_q[i]);
    end
    scaled  = total >> COEF_FRAC_BITS;
    sat_pix = (scaled > TOTAL_W'(PIX_MAX)) ? PIX_W'(PIX_MAX) : scaled[PIX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      a_valid_q <= 1'b0;
    end else begin
      p_valid_q <= sum_valid_i;
      a_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    p_tag_q <= tag_i;
    pair_q  <= pair_d;
    a_tag_q <= p_tag_q;
  end

  assign done_o          = a_valid_q;
  assign push_o          = a_valid_q && a_tag_q.emit;
  assign res_o.pixel_out = a_tag_q.inner ? sat_pix : '0;
  assign res_o.out_x     = a_tag_q.out_x;
  assign res_o.out_y     = a_tag_q.out_y;

endmodule

>>> design/gb2d_out_fifo.sv
// Result queue between the arithmetic pipeline and the output channel.
`timescale 1ns / 1ps

module gb2d_out_fifo
  import gb2d_pkg::*;
#(
  parameter int DEPTH = OUT_FIFO_DEPTH,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  out_item_t     push_data_i,
  input  logic          pop_i,
  output logic          valid_o,
  output out_item_t     data_o,
  output logic [CW-1:0] count_o
);

  out_item_t     fifo_mem [DEPTH];
  logic [PW-1:0] wr_ptr_q;
  logic [PW-1:0] rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_pop;

  assign valid_o = (cnt_q != '0);
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_mem[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  assign data_o  = fifo_mem[rd_ptr_q];
  assign count_o = cnt_q;

endmodule

>>> design/gaussian_blur_2d_stream.sv
// Top level of the streaming 5x5 Gaussian blur over 8-bit grey pixels.
//
// Takes one pixel per clock in raster order unless stalled, and emits the blurred
// pixel for the window center two columns and two rows behind the newest pixel;
// rows and columns before that point give no result, and the last two of each are
// never sent. Centers closer than the kernel size to any frame edge come out as 0.
// Weights are six unsigned Q2.14 distance-class coefficients written over the config
// port while the block is idle; the weighted sum is floored by 14 bits and saturated
// at 255. Sustained rate is one pixel per clock while the output is not stalled:
// the line buffer is a single memory of one word per column (four stored rows) that
// is read at accept and written back in the following cycle, with a bypass for
// back-to-back hits on the same column (one-pixel-wide frames, or a start of frame
// at column 0 repeated). A result passes the stage-1, window and weighting registers
// before it enters the output queue, which holds eight results; in_stall_o rises
// when pixels in flight plus queued results reach eight, so a stalled consumer backs
// up into the input once the queue has no room left for the pixels still in flight.
// The line buffer is not cleared at reset; its contents only reach a computed pixel
// after they have been written by the current frame's earlier rows.
`timescale 1ns / 1ps

module gaussian_blur_2d_stream
  import gb2d_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  // Wide enough for both the width register and the MAX_WIDTH clamp.
  localparam int EW    = ($clog2(MAX_WIDTH + 1) > IMG_W_W) ? $clog2(MAX_WIDTH + 1) : IMG_W_W;
  localparam int CNT_W = $clog2(OUT_FIFO_DEPTH + 1);

  // Configuration registers
  logic [IMG_W_W-1:0]         width_q;
  logic [IMG_H_W-1:0]         height_q;
  coef_t [NUM_CLASSES-1:0]    coef_q;

  // Effective frame size after the zero and MAX_WIDTH corrections
  logic [EW-1:0]              w_ext;
  logic [EW-1:0]              eff_w;
  logic [IMG_H_W-1:0]         eff_h;

  // Raster position counters
  logic [COL_W-1:0]           col_q, col_d, col_cur;
  logic [IMG_H_W-1:0]         row_q, row_d, row_cur;

  // Stage 1: accepted pixel waiting for its line buffer word
  logic                       s1_valid_q;
  pix_t                       s1_pix_q;
  logic [COL_W-1:0]           s1_col_q;
  logic [IMG_H_W-1:0]         s1_row_q;

  logic                       in_acc;
  lb_word_t                   lb_rd;
  lb_word_t                   lb_wr;
  col_t                       column;
  gb2d_tag_t                  s1_tag;
  logic [EW:0]                col_e;
  logic [IMG_H_W:0]           row_e;

  logic                       sum_valid;
  cls_sum_t [NUM_CLASSES-1:0] cls_sums;
  gb2d_tag_t                  sum_tag;
  logic                       mac_done;
  logic                       mac_push;
  out_item_t                  mac_res;

  logic [CNT_W-1:0]           inflight_q;
  logic [CNT_W-1:0]           fifo_cnt;
  logic [CNT_W:0]             occupancy;

  // ---------------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_IMAGE_WIDTH;
      height_q <= RST_IMAGE_HEIGHT;
      coef_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:  width_q         <= cfg_data_i[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: height_q        <= cfg_data_i[IMG_H_W-1:0];
        REG_COEF_D00:     coef_q[CLS_D00] <= cfg_data_i[COEF_W-1:0];
        REG_COEF_D01:     coef_q[CLS_D01] <= cfg_data_i[COEF_W-1:0];
        REG_COEF_D11:     coef_q[CLS_D11] <= cfg_data_i[COEF_W-1:0];
        REG_COEF_D02:     coef_q[CLS_D02] <= cfg_data_i[COEF_W-1:0];
        REG_COEF_D12:     coef_q[CLS_D12] <= cfg_data_i[COEF_W-1:0];
        REG_COEF_D22:     coef_q[CLS_D22] <= cfg_data_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Treat a zero size as one and clamp the width to the line buffer depth.
  always_comb begin
    w_ext = EW'(width_q);
    if (w_ext == '0) begin
      eff_w = EW'(1);
    end else if (w_ext > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = w_ext;
    end
    eff_h = (height_q == '0) ? IMG_H_W'(1) : height_q;
  end

  // ---------------------------------------------------------------------------
  // Input transfer and raster position
  // ---------------------------------------------------------------------------
  // Hold off new pixels once everything in flight could fill the output queue.
  assign occupancy  = (CNT_W + 1)'(inflight_q) + (CNT_W + 1)'(fifo_cnt);
  assign in_stall_o = (occupancy >= (CNT_W + 1)'(OUT_FIFO_DEPTH));
  assign in_acc     = in_valid_i && !in_stall_o;

  // Start of frame, or a size change that left the counters out of range,
  // restarts at the origin.
  always_comb begin
    if (in_data_i.start_of_frame || (EW'(col_q) >= eff_w)) begin
      col_cur = '0;
    end else begin
      col_cur = col_q;
    end
    if (in_data_i.start_of_frame || (row_q >= eff_h)) begin
      row_cur = '0;
    end else begin
      row_cur = row_q;
    end
    if ((EW'(col_cur) + EW'(1)) >= eff_w) begin
      col_d = '0;
      row_d = ((IMG_H_W + 1)'(row_cur) + (IMG_H_W + 1)'(1) >= (IMG_H_W + 1)'(eff_h)) ?
              '0 : row_cur + IMG_H_W'(1);
    end else begin
      col_d = col_cur + COL_W'(1);
      row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q <= in_data_i.pixel_in;
      s1_col_q <= col_cur;
      s1_row_q <= row_cur;
    end
  end

  // ---------------------------------------------------------------------------
  // Line buffer: read at accept, write the shifted column back in stage 1
  // ---------------------------------------------------------------------------
  gb2d_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (col_cur),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_col_q),
    .wr_data_i (lb_wr),
    .rd_data_o (lb_rd)
  );

  // Oldest row at the bottom of the column, newest pixel at the top; each stored
  // row moves down one slot on write back.
  always_comb begin
    for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
      column[j] = lb_rd[j];
    end
    column[KERNEL_SIZE-1] = s1_pix_q;
    for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
      lb_wr[j] = column[j+1];
    end
  end

  // Result flags: emit once the window center exists, compute only well inside
  // the frame, zero elsewhere.
  always_comb begin
    col_e        = (EW + 1)'(s1_col_q);
    row_e        = (IMG_H_W + 1)'(s1_row_q);
    s1_tag.emit  = (s1_col_q >= COL_W'(HALF_K)) && (s1_row_q >= IMG_H_W'(HALF_K));
    s1_tag.inner = (col_e >= (EW + 1)'(HALF_K + KERNEL_SIZE)) &&
                   ((col_e + (EW + 1)'(KERNEL_SIZE - HALF_K)) < (EW + 1)'(eff_w)) &&
                   (row_e >= (IMG_H_W + 1)'(HALF_K + KERNEL_SIZE)) &&
                   ((row_e + (IMG_H_W + 1)'(KERNEL_SIZE - HALF_K)) <
                    (IMG_H_W + 1)'(eff_h));
    s1_tag.out_x = OUT_X_W'(s1_col_q - COL_W'(HALF_K));
    s1_tag.out_y = OUT_Y_W'(s1_row_q - IMG_H_W'(HALF_K));
  end

  // ---------------------------------------------------------------------------
  // Window, class sums and weighting
  // ---------------------------------------------------------------------------
  gb2d_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .col_valid_i (s1_valid_q),
    .column_i    (column),
    .tag_i       (s1_tag),
    .sum_valid_o (sum_valid),
    .sums_o      (cls_sums),
    .tag_o       (sum_tag)
  );

  gb2d_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sum_valid_i (sum_valid),
    .sums_i      (cls_sums),
    .tag_i       (sum_tag),
    .coefs_i     (coef_q),
    .done_o      (mac_done),
    .push_o      (mac_push),
    .res_o       (mac_res)
  );

  // Count pixels between accept and the end of the pipeline, result or not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_acc && !mac_done) begin
      inflight_q <= inflight_q + CNT_W'(1);
    end else if (mac_done && !in_acc) begin
      inflight_q <= inflight_q - CNT_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Output queue; a result leaves on each output transfer
  // ---------------------------------------------------------------------------
  gb2d_out_fifo #(
    .DEPTH (OUT_FIFO_DEPTH)
  ) u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (mac_push),
    .push_data_i (mac_res),
    .pop_i       (!out_stall_i),
    .valid_o     (out_valid_o),
    .data_o      (out_data_o),
    .count_o     (fifo_cnt)
  );

endmodule

>>> design/gb2d_checker.sv
// Port-level checker for the Gaussian blur block and its bind to the top level.
`timescale 1ns / 1ps
`include "gaussian_blur_2d_stream_macros.svh"

module gb2d_checker
  import gb2d_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // Highest center row: last row of the tallest frame, two rows back.
  localparam int Y_LAST = (2 ** IMG_H_W) - 2 - HALF_K;

  `GB2D_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed or dropped")

  `GB2D_ASSERT_NOW(a_border_zero, out_valid_o && (out_data_o.out_x < OUT_X_W'(KERNEL_SIZE) || out_data_o.out_y < OUT_Y_W'(KERNEL_SIZE)), out_data_o.pixel_out == '0, "border result not zero")

  `GB2D_ASSERT_NOW(a_row_range, out_valid_o, out_data_o.out_y <= OUT_Y_W'(Y_LAST), "result row beyond last center row")

  `GB2D_ASSERT_NOW(a_reset_empty, $rose(rst_ni), !in_stall_o && !out_valid_o, "block not empty after reset")

endmodule

bind gaussian_blur_2d_stream gb2d_checker u_gb2d_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

>>> sim/gaussian_blur_2d_stream_tb.sv
// Self-checking testbench for the streaming 5x5 Gaussian blur: random frames against a predictor.
`timescale 1ns / 1ps

module gaussian_blur_2d_stream_tb;
  import gb2d_pkg::*;

  localparam int MAX_W          = DEF_MAX_WIDTH;
  localparam int RANDOM_PIXELS  = 900;
  localparam int SETTLE_CYCLES  = 32;    // long enough for the pipeline to drain
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer or config write
  localparam int MAX_WAIT       = 18;
  localparam int PRINT_LIMIT    = 60;

  // How often a side idles or stalls between transfers.
  typedef enum int {
    PACE_NONE,
    PACE_SPARSE,
    PACE_HEAVY
  } pace_e;

  // Kernel weight sets loaded between phases.
  typedef enum int {
    KERN_ZERO,
    KERN_MAX,
    KERN_GAUSS,
    KERN_WIDE,
    KERN_MILD
  } kern_e;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i  = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;

  gaussian_blur_2d_stream uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Pixels waiting to be driven, and blurred pixels waiting to come out.
  in_item_t  pixel_q[$];
  out_item_t blurred_q[$];

  pace_e in_pace  = PACE_NONE;
  pace_e out_pace = PACE_NONE;
  int    in_wait;
  int    out_wait;
  int    idle_cycles = 0;
  int    err_count   = 0;
  out_item_t want;

  // Shadow of the block: registers, line buffers, window and raster position.
  logic [IMG_W_W-1:0] shadow_width  = RST_IMAGE_WIDTH;
  logic [IMG_H_W-1:0] shadow_height = RST_IMAGE_HEIGHT;
  bit   [COEF_W-1:0]  shadow_coef [NUM_CLASSES];
  bit   [PIX_W-1:0]   line_mem [KERNEL_SIZE-1][MAX_W];
  bit   [PIX_W-1:0]   win [KERNEL_SIZE][KERNEL_SIZE];
  int unsigned        col_pos = 0;
  int unsigned        row_pos = 0;

  // Print one mismatch line (up to a cap) and count it.
  task automatic report_mismatch(string field, int unsigned x, int unsigned y,
                                 logic [31:0] got, logic [31:0] want_v);
    if (err_count < PRINT_LIMIT) begin
      $display("%s mismatch at (%0d, %0d): got %0d, want %0d", field, x, y, got, want_v);
    end
    err_count++;
  endtask

  // Advance the shadow by one accepted pixel; queue the blurred pixel it releases.
  task automatic blur_step(input in_item_t px);
    int unsigned     w;
    int unsigned     h;
    int unsigned     cx;
    int unsigned     cy;
    int unsigned     dx;
    int unsigned     dy;
    int unsigned     j;
    int unsigned     r;
    int unsigned     c;
    bit [PIX_W-1:0]  column [KERNEL_SIZE];
    longint unsigned acc;
    bit [COEF_W-1:0] wt;
    out_item_t       res;
    // Clamp the geometry the way the block does.
    w = (shadow_width == 0) ? 1 : shadow_width;
    if (w > MAX_W) w = MAX_W;
    h = (shadow_height == 0) ? 1 : shadow_height;
    if (px.start_of_frame) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    // Gather the column: oldest stored row first, new pixel last; push rows up.
    for (j = 0; j < KERNEL_SIZE - 1; j++) column[j] = line_mem[j][col_pos];
    column[KERNEL_SIZE-1] = px.pixel_in;
    for (j = 0; j < KERNEL_SIZE - 1; j++) line_mem[j][col_pos] = column[j+1];
    // Shift the window left and drop the new column in on the right.
    for (r = 0; r < KERNEL_SIZE; r++) begin
      for (c = 0; c < KERNEL_SIZE - 1; c++) win[r][c] = win[r][c+1];
      win[r][KERNEL_SIZE-1] = column[r];
    end
    if (col_pos >= HALF_K && row_pos >= HALF_K) begin
      cx = col_pos - HALF_K;
      cy = row_pos - HALF_K;
      res.pixel_out = '0;
      // Only centers a full kernel away from every edge get a computed value.
      if (cx >= KERNEL_SIZE && cx + KERNEL_SIZE < w &&
          cy >= KERNEL_SIZE && cy + KERNEL_SIZE < h) begin
        acc = 0;
        for (r = 0; r < KERNEL_SIZE; r++) begin
          for (c = 0; c < KERNEL_SIZE; c++) begin
            dy = (r >= HALF_K) ? r - HALF_K : HALF_K - r;
            dx = (c >= HALF_K) ? c - HALF_K : HALF_K - c;
            // Weight by squared distance from the center.
            case (dx * dx + dy * dy)
              0:       wt = shadow_coef[CLS_D00];
              1:       wt = shadow_coef[CLS_D01];
              2:       wt = shadow_coef[CLS_D11];
              4:       wt = shadow_coef[CLS_D02];
              5:       wt = shadow_coef[CLS_D12];
              default: wt = shadow_coef[CLS_D22];
            endcase
            acc += longint'(win[r][c]) * longint'(wt);
          end
        end
        acc = acc >> COEF_FRAC_BITS;
        res.pixel_out = (acc > PIX_MAX) ? PIX_W'(PIX_MAX) : PIX_W'(acc);
      end
      res.out_x = OUT_X_W'(cx);
      res.out_y = OUT_Y_W'(cy);
      blurred_q.push_back(res);
    end
    // Step the raster position; wrap the frame even without a start marker.
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  function automatic int draw_wait(pace_e pace);
    case (pace)
      PACE_NONE:   return 0;
      PACE_SPARSE: return ($urandom_range(0, 5) == 0) ? $urandom_range(1, MAX_WAIT) : 0;
      default:     return $urandom_range(0, MAX_WAIT);
    endcase
  endfunction

  // Favor the extremes so saturation and dark regions show up often.
  function automatic pix_t draw_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Write one register while the block is idle and mirror it in the shadow.
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:  shadow_width  = data[IMG_W_W-1:0];
      REG_IMAGE_HEIGHT: shadow_height = data[IMG_H_W-1:0];
      REG_COEF_D00:     shadow_coef[CLS_D00] = data;
      REG_COEF_D01:     shadow_coef[CLS_D01] = data;
      REG_COEF_D11:     shadow_coef[CLS_D11] = data;
      REG_COEF_D02:     shadow_coef[CLS_D02] = data;
      REG_COEF_D12:     shadow_coef[CLS_D12] = data;
      default:          shadow_coef[CLS_D22] = data;
    endcase
  endtask

  // Load frame geometry; junk in the unused upper data bits must be ignored.
  task automatic set_frame(int unsigned w, int unsigned h);
    write_reg(REG_IMAGE_WIDTH, {(CFG_DATA_W-IMG_W_W)'($urandom), IMG_W_W'(w)});
    write_reg(REG_IMAGE_HEIGHT, {(CFG_DATA_W-IMG_H_W)'($urandom), IMG_H_W'(h)});
  endtask

  task automatic program_kernel(kern_e mode);
    bit [COEF_W-1:0] k [NUM_CLASSES];
    int              i;
    case (mode)
      KERN_GAUSS: begin
        // Sigma of one, normalized to unity gain in Q2.14.
        k[CLS_D00] = 16'd2656;
        k[CLS_D01] = 16'd1611;
        k[CLS_D11] = 16'd977;
        k[CLS_D02] = 16'd359;
        k[CLS_D12] = 16'd218;
        k[CLS_D22] = 16'd49;
      end
      default: begin
        for (i = 0; i < NUM_CLASSES; i++) begin
          if (mode == KERN_ZERO) k[i] = '0;
          else if (mode == KERN_MAX) k[i] = '1;
          else if (mode == KERN_WIDE) k[i] = COEF_W'($urandom);
          else k[i] = COEF_W'($urandom_range(0, 1200));
        end
      end
    endcase
    write_reg(REG_COEF_D00, k[CLS_D00]);
    write_reg(REG_COEF_D01, k[CLS_D01]);
    write_reg(REG_COEF_D11, k[CLS_D11]);
    write_reg(REG_COEF_D02, k[CLS_D02]);
    write_reg(REG_COEF_D12, k[CLS_D12]);
    write_reg(REG_COEF_D22, k[CLS_D22]);
  endtask

  task automatic push_pixel(pix_t p, bit sof);
    pixel_q.push_back('{pixel_in: p, start_of_frame: sof});
  endtask

  // Queue a run of random pixels, optionally marking the first as frame start.
  task automatic queue_pixels(int unsigned count, bit sof_first);
    int unsigned n;
    for (n = 0; n < count; n++) push_pixel(draw_pixel(), (n == 0) && sof_first);
  endtask

  // Wait until every pixel is in and every blurred pixel is out, then let the pipe go quiet.
  task automatic settle();
    @(negedge clk_i);
    while (pixel_q.size() != 0 || in_valid_i || blurred_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Driver: present queued pixels, hold each until its transfer, then idle as drawn.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      in_wait = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        blur_step(in_data_i);
      end
      // Only move on once the current pixel is gone; a stalled payload stays put.
      if (!in_valid_i || !in_stall_o) begin
        if (in_wait > 0) begin
          in_wait--;
          in_valid_i <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          in_data_i  <= pixel_q.pop_front();
          in_valid_i <= 1'b1;
          in_wait = draw_wait(in_pace);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check every output transfer against the oldest blurred pixel; stall as drawn.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (blurred_q.size() == 0) begin
          report_mismatch("unexpected result", out_data_o.out_x, out_data_o.out_y,
                          out_data_o.pixel_out, 0);
        end else begin
          want = blurred_q.pop_front();
          if (out_data_o.pixel_out !== want.pixel_out) begin
            report_mismatch("pixel_out", want.out_x, want.out_y,
                            out_data_o.pixel_out, want.pixel_out);
          end
          if (out_data_o.out_x !== want.out_x) begin
            report_mismatch("out_x", want.out_x, want.out_y, out_data_o.out_x, want.out_x);
          end
          if (out_data_o.out_y !== want.out_y) begin
            report_mismatch("out_y", want.out_x, want.out_y, out_data_o.out_y, want.out_y);
          end
        end
        out_wait = draw_wait(out_pace);
      end
      if (out_wait > 0) begin
        out_stall_i <= 1'b1;
        out_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: drop out if nothing moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("gaussian_blur_2d_stream regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned random_pixels;
    int unsigned fw;
    int unsigned fh;
    int unsigned frame_len;
    int unsigned kpick;
    int unsigned kind;
    int unsigned n;
    random_pixels = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero width acts as one column: the position never leaves column 0, so nothing comes out.
    program_kernel(KERN_GAUSS);
    set_frame(0, 1);
    push_pixel(8'h00, 1'b1);
    push_pixel(8'hFF, 1'b0);
    push_pixel(8'h80, 1'b1);
    settle();

    // Zero height acts as one row: warm-up never ends.
    set_frame(5, 0);
    for (n = 0; n < 6; n++) push_pixel((n % 2) ? 8'hFF : 8'h00, n == 0);
    settle();

    // Tiny 3x3 frame: one border result per frame, then a wrap without start marker,
    // then repeated frame starts that keep hitting column 0.
    in_pace  = PACE_SPARSE;
    out_pace = PACE_HEAVY;
    set_frame(3, 3);
    for (n = 0; n < 9; n++) push_pixel((n % 2) ? 8'h00 : 8'hFF, n == 0);
    for (n = 0; n < 9; n++) push_pixel((n % 3) ? 8'hFF : 8'h00, 1'b0);
    push_pixel(8'hFF, 1'b1);
    push_pixel(8'h00, 1'b1);
    push_pixel(8'hFF, 1'b1);
    settle();

    // Random phases: mostly frames large enough for computed centers, a few degenerate ones.
    while (random_pixels < RANDOM_PIXELS) begin
      if ($urandom_range(0, 9) < 8) begin
        fw = $urandom_range(11, 24);
        fh = $urandom_range(11, 16);
      end else begin
        fw = $urandom_range(0, 12);
        fh = $urandom_range(0, 12);
      end
      set_frame(fw, fh);
      kpick = $urandom_range(0, 9);
      program_kernel(kpick == 0 ? KERN_ZERO : kpick == 1 ? KERN_MAX :
                     kpick < 5 ? KERN_GAUSS : kpick == 5 ? KERN_WIDE : KERN_MILD);
      in_pace   = pace_e'($urandom_range(0, 2));
      out_pace  = pace_e'($urandom_range(0, 2));
      frame_len = ((fw == 0) ? 1 : fw) * ((fh == 0) ? 1 : fh);
      // Open with a full frame so every column of the new width is written
      // before a computed center reads it.
      queue_pixels(frame_len, 1'b1);
      repeat ($urandom_range(0, 2)) begin
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
          queue_pixels(frame_len, 1'b1);
        end else if (kind == 7) begin
          // Carry on from wherever the last frame stopped.
          queue_pixels(frame_len, 1'b0);
        end else if (kind == 8) begin
          // Cut the frame short; the next start marker restarts mid-frame.
          queue_pixels($urandom_range(1, frame_len), 1'b1);
        end else begin
          // Noise: start markers at random.
          for (n = $urandom_range(3, 8); n > 0; n--) push_pixel(draw_pixel(), $urandom_range(0, 1));
        end
      end
      random_pixels += pixel_q.size();
      settle();
    end

    // Widest frames: width above the limit saturates, height at its maximum.
    in_pace  = PACE_NONE;
    out_pace = PACE_SPARSE;
    program_kernel(KERN_MILD);
    set_frame(2047, 4095);
    queue_pixels(2 * MAX_W + 8, 1'b1);
    settle();

    if (err_count == 0) begin
      $display("gaussian_blur_2d_stream regression: pass");
    end else begin
      $display("gaussian_blur_2d_stream regression: fail");
    end
    $finish;
  end

endmodule
